// ----- hw/rtl/der_tlv_header_parser_unit_assert.svh -----
// Assertion macros used by the DER TLV parser checker
`ifndef DER_TLV_HEADER_PARSER_UNIT_ASSERT_SVH
`define DER_TLV_HEADER_PARSER_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is high
`define DTLV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset
`define DTLV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/dtlv_pkg.sv -----
// Shared types and constants of the DER TLV header parser
`default_nettype none
package dtlv_pkg;

  localparam int MAX_LENGTH_OCTETS = 4;
  localparam int LO_W = $clog2(MAX_LENGTH_OCTETS + 1);

  localparam logic [4:0] TAG_LONG_FORM = 5'h1F;
  localparam logic [7:0] LEN_INDEFINITE = 8'h80;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TAG_LONG   = 3'd1;
  localparam logic [2:0] ERR_INDEFINITE = 3'd2;
  localparam logic [2:0] ERR_LEN_OCTETS = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd4;

  typedef enum logic [2:0] {
    PH_IDENT   = 3'd0,
    PH_TAG2    = 3'd1,
    PH_LEN     = 3'd2,
    PH_LENOCT  = 3'd3,
    PH_VALUE   = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [7:0]  value_byte;
    logic [31:0] elem_length;
    logic        is_context_specific;
    logic        is_constructed;
    logic [6:0]  tag_number;
    logic [1:0]  kind;
    logic        last_of_element;
  } result_t;

  // Push request from the parser core to the output buffer
  typedef struct packed {
    logic push;
  } out_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dtlv_in_reg.sv -----
// Input register: holds one accepted byte until the parser core consumes it
`default_nettype none
module dtlv_in_reg import dtlv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output      logic       s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       s_tlast,
  input  wire logic       consume,
  output      logic       item_valid,
  output      in_item_t   item
);

  assign s_tready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.data_byte  <= s_tdata;
      item.buffer_end <= s_tlast;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dtlv_core.sv -----
// Parser core: TLV state registers and the per-byte decode logic
`default_nettype none
module dtlv_core import dtlv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire in_item_t item,
  input  wire logic     out_can_take,
  output      logic     consume,
  output      logic     res_valid,
  output      result_t  res
);

  phase_t        phase, phase_next;
  logic [6:0]    held_tag, held_tag_next;
  logic [1:0]    held_flags, held_flags_next;
  logic [LO_W-1:0] lo_left, lo_left_next;
  logic [31:0]   length_accum, length_accum_next;
  logic [31:0]   value_left, value_left_next;

  logic [7:0]    b;
  logic          fin;
  logic [31:0]   acc;
  logic [31:0]   vl;
  logic          len_done;

  assign consume = item_valid && out_can_take;
  assign b   = item.data_byte;
  assign fin = item.buffer_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDENT;
      held_tag     <= '0;
      held_flags   <= '0;
      lo_left      <= '0;
      length_accum <= '0;
      value_left   <= '0;
    end else if (consume) begin
      phase        <= phase_next;
      held_tag     <= held_tag_next;
      held_flags   <= held_flags_next;
      lo_left      <= lo_left_next;
      length_accum <= length_accum_next;
      value_left   <= value_left_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    held_tag_next     = held_tag;
    held_flags_next   = held_flags;
    lo_left_next      = lo_left;
    length_accum_next = length_accum;
    value_left_next   = value_left;
    res_valid         = 1'b0;
    res               = '0;
    acc               = length_accum;
    vl                = value_left - {31'd0, (value_left != 32'd0)};
    len_done          = 1'b0;

    unique case (phase)
      PH_IDENT: begin
        held_flags_next = {b[5], b[7]};
        held_tag_next   = {2'b00, b[4:0]};
        phase_next      = (b[4:0] == TAG_LONG_FORM) ? PH_TAG2 : PH_LEN;
        if (fin) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
          phase_next     = PH_IDENT;
        end
      end
      PH_TAG2: begin
        if (b[7]) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TAG_LONG;
          phase_next     = fin ? PH_IDENT : PH_DISCARD;
        end else begin
          held_tag_next = b[6:0];
          phase_next    = PH_LEN;
          if (fin) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
            phase_next     = PH_IDENT;
          end
        end
      end
      PH_LEN: begin
        if (!b[7]) begin
          acc      = {24'd0, b};
          len_done = 1'b1;
        end else if (b == LEN_INDEFINITE) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_INDEFINITE;
          phase_next     = fin ? PH_IDENT : PH_DISCARD;
        end else if (b[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_LEN_OCTETS;
          phase_next     = fin ? PH_IDENT : PH_DISCARD;
        end else begin
          lo_left_next      = b[LO_W-1:0];
          length_accum_next = '0;
          phase_next        = PH_LENOCT;
          if (fin) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
            phase_next     = PH_IDENT;
          end
        end
      end
      PH_LENOCT: begin
        acc          = {length_accum[23:0], b};
        lo_left_next = lo_left - {{(LO_W-1){1'b0}}, (lo_left != '0)};
        if (lo_left_next == '0) begin
          len_done = 1'b1;
        end else begin
          length_accum_next = acc;
          if (fin) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
            phase_next     = PH_IDENT;
          end
        end
      end
      PH_VALUE: begin
        value_left_next = vl;
        res_valid       = 1'b1;
        if (vl == 32'd0) begin
          res.kind            = KIND_VALUE;
          res.elem_length     = length_accum;
          res.value_byte      = b;
          res.last_of_element = 1'b1;
          phase_next          = PH_IDENT;
        end else if (fin) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
          phase_next     = PH_IDENT;
        end else begin
          res.kind        = KIND_VALUE;
          res.elem_length = length_accum;
          res.value_byte  = b;
        end
      end
      default: begin
        // drop bytes until the end of the buffer
        if (fin) phase_next = PH_IDENT;
      end
    endcase

    // length complete: emit the header, or flag a cut-off element
    if (len_done) begin
      length_accum_next = acc;
      res_valid         = 1'b1;
      if (acc == 32'd0) begin
        res.kind   = KIND_HEADER;
        phase_next = PH_IDENT;
      end else if (fin) begin
        res.kind       = KIND_ERROR;
        res.error_code = ERR_TRUNCATED;
        phase_next     = PH_IDENT;
      end else begin
        value_left_next = acc;
        res.kind        = KIND_HEADER;
        res.elem_length = acc;
        phase_next      = PH_VALUE;
      end
    end

    if (res.kind == KIND_ERROR || res.elem_length == 32'd0) res.last_of_element = 1'b1;
    if (res.kind == KIND_VALUE && vl != 32'd0) res.last_of_element = 1'b0;
    res.tag_number          = held_tag_next;
    res.is_constructed      = held_flags_next[1];
    res.is_context_specific = held_flags_next[0];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dtlv_out_buf.sv -----
// Output register with a skid entry; the core waits on m_tready only while the skid entry is full
`default_nettype none
module dtlv_out_buf import dtlv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire out_ctl_t ctl_in,
  output      logic     can_take,
  input  wire result_t  res,
  output      logic     m_tvalid,
  input  wire logic     m_tready,
  output      result_t  head
);

  logic    skid_valid;
  result_t skid;

  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      m_tvalid   <= skid_valid || ctl_in.push;
      skid_valid <= 1'b0;
    end else if (ctl_in.push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      head <= skid_valid ? skid : res;
    end else if (ctl_in.push) begin
      skid <= res;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/der_tlv_header_parser_unit.sv -----
// DER TLV header parser: splits a DER byte stream into header and value results
//
// Input channel s_*: one buffer byte per transfer in s_tdata, s_tlast on the
// final byte of the buffer. Output channel m_*: one result per transfer,
// m_tuser carries the kind (header, value byte, error), m_tlast marks the
// final result of an element (always set on errors).
// Throughput: one byte per cycle, sustained, as long as m_tready stays high.
// A byte is decoded from the input register; its result is registered.
// Identifier, second tag and length-count bytes, and all but the final
// length octet, give no result unless they raise an error.
// Reset (rst, synchronous) empties the input register, the output register
// and the skid entry, and returns the parser to expecting an identifier byte.
// When the receiver stalls, the output register holds its result and one
// more result goes to the skid entry; the core then waits, and s_tready drops
// once the input register holds a byte, until the skid entry drains, so no
// result is lost. s_tready depends on registers only.
`default_nettype none
module der_tlv_header_parser_unit import dtlv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
  input  wire logic        s_tlast,  // buffer_end
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // [6:0] tag_number, [7] is_constructed, [8] is_context_specific,
  // [40:9] elem_length, [48:41] value_byte, [51:49] error_code, [55:52] zero
  output      logic [55:0] m_tdata,
  output      logic [1:0]  m_tuser,  // kind
  output      logic        m_tlast   // last_of_element
);

  logic     item_valid;
  in_item_t item;
  logic     consume;
  logic     res_valid;
  result_t  res;
  result_t  head;
  out_ctl_t ctl;
  logic     can_take;

  dtlv_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  dtlv_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .out_can_take (can_take),
    .consume      (consume),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign ctl.push = consume && res_valid;

  dtlv_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl),
    .can_take (can_take),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {4'd0, head.error_code, head.value_byte, head.elem_length,
                    head.is_context_specific, head.is_constructed, head.tag_number};
  assign m_tuser = head.kind;
  assign m_tlast = head.last_of_element;

endmodule
`default_nettype wire

// ----- hw/rtl/dtlv_checker.sv -----
// Port-level checker for the DER TLV header parser, bound to the top level
`default_nettype none
`include "der_tlv_header_parser_unit_assert.svh"
module dtlv_checker import dtlv_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  `DTLV_ASSERT(a_stall_hold,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
    "result changed while stalled")
  `DTLV_ASSERT(a_err_last,
    m_tvalid && m_tuser == KIND_ERROR |-> m_tlast && m_tdata[48:9] == 40'd0,
    "error result not closing element")
  `DTLV_ASSERT(a_hdr_last,
    m_tvalid && m_tuser == KIND_HEADER |-> m_tlast == (m_tdata[40:9] == 32'd0),
    "header last flag does not match length")
  `DTLV_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !m_tvalid, "result valid right after reset")

endmodule

bind der_tlv_header_parser_unit dtlv_checker u_dtlv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- dv/tb_der_tlv_header_parser_unit.sv -----
// Self-checking testbench for the DER TLV header parser: directed table, then random buffers
`default_nettype none
module tb_der_tlv_header_parser_unit;
  import dtlv_pkg::*;

  localparam int ITEM_TARGET    = 1300;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam logic [7:0] LONG_LEN_FLAG = 8'h80;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  tag;
    logic        cons;
    logic        ctx;
    logic [31:0] len;
    logic [7:0]  vbyte;
    logic [2:0]  err;
    logic        last;
  } tlv_result_t;

  localparam tlv_result_t NO_RESULT = '0;

  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    tlv_result_t want;
  } dir_row_t;

  typedef struct packed {
    logic        typed;
    tlv_result_t want;
  } offer_mark_t;

  // data, buffer end, typed, {kind, tag, cons, ctx, len, value, error, last}
  localparam dir_row_t DIRECTED_ROWS [24] = '{
    '{8'h02, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b1, '{KIND_HEADER, 7'd2, 1'b0, 1'b0, 32'd0, 8'd0, ERR_NONE, 1'b1}},
    '{8'hBF, 1'b0, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, 1'b0, NO_RESULT},
    '{8'h82, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h1F, 1'b0, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, 1'b1,
      '{KIND_ERROR, 7'h1F, 1'b0, 1'b0, 32'd0, 8'd0, ERR_TAG_LONG, 1'b1}},
    '{8'h11, 1'b1, 1'b0, NO_RESULT},
    '{8'h30, 1'b0, 1'b0, NO_RESULT},
    '{8'h80, 1'b1, 1'b1,
      '{KIND_ERROR, 7'h10, 1'b1, 1'b0, 32'd0, 8'd0, ERR_INDEFINITE, 1'b1}},
    '{8'h04, 1'b0, 1'b0, NO_RESULT},
    '{8'h85, 1'b1, 1'b1,
      '{KIND_ERROR, 7'd4, 1'b0, 1'b0, 32'd0, 8'd0, ERR_LEN_OCTETS, 1'b1}},
    '{8'h04, 1'b1, 1'b1,
      '{KIND_ERROR, 7'd4, 1'b0, 1'b0, 32'd0, 8'd0, ERR_TRUNCATED, 1'b1}},
    '{8'hC4, 1'b0, 1'b0, NO_RESULT},
    '{8'h84, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b1,
      '{KIND_HEADER, 7'd4, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'd0, ERR_NONE, 1'b0}},
    '{8'h5A, 1'b1, 1'b1,
      '{KIND_ERROR, 7'd4, 1'b0, 1'b1, 32'd0, 8'd0, ERR_TRUNCATED, 1'b1}}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  der_tlv_header_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state mirror
  phase_t             parse_phase;
  logic [6:0]         cur_tag;
  logic [1:0]         cur_flags;  // bit 1 constructed, bit 0 context specific
  logic [LO_W-1:0]    len_octets_left;
  logic [31:0]        len_accum;
  logic [31:0]        content_left;

  tlv_result_t        pending_results [$];
  offer_mark_t        offer_marks [$];
  tlv_result_t        predicted;
  tlv_result_t        oldest;
  offer_mark_t        mark;
  bit                 produced;
  bit                 calm;
  bit                 pressure_done;
  int                 fail_count;
  int                 results_seen;
  int                 items_sent;
  int                 quiet_cycles;
  int                 rx_stall;

  function automatic tlv_result_t tlv_out(input logic [1:0] kind, input logic [31:0] len,
                                          input logic [7:0] vb, input logic [2:0] err,
                                          input logic last);
    tlv_result_t r;
    r.kind  = kind;
    r.tag   = cur_tag;
    r.cons  = cur_flags[1];
    r.ctx   = cur_flags[0];
    r.len   = len;
    r.vbyte = vb;
    r.err   = err;
    r.last  = last;
    return r;
  endfunction

  function automatic bit error_out(input logic [2:0] code, input logic fin,
                                   output tlv_result_t r);
    r = tlv_out(KIND_ERROR, 32'd0, 8'd0, code, 1'b1);
    parse_phase = fin ? PH_IDENT : PH_DISCARD;
    return 1'b1;
  endfunction

  function automatic bit length_complete(input logic fin, output tlv_result_t r);
    if (len_accum == 32'd0) begin
      r = tlv_out(KIND_HEADER, 32'd0, 8'd0, ERR_NONE, 1'b1);
      parse_phase = PH_IDENT;
      return 1'b1;
    end
    if (fin) return error_out(ERR_TRUNCATED, 1'b1, r);
    content_left = len_accum;
    r = tlv_out(KIND_HEADER, len_accum, 8'd0, ERR_NONE, 1'b0);
    parse_phase = PH_VALUE;
    return 1'b1;
  endfunction

  // Advance the mirror by one byte; return 1 when the byte yields a result
  function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                     output tlv_result_t r);
    r = NO_RESULT;
    case (parse_phase)
      PH_IDENT: begin
        cur_flags   = {b[5], b[7]};
        cur_tag     = {2'b00, b[4:0]};
        parse_phase = (b[4:0] == TAG_LONG_FORM) ? PH_TAG2 : PH_LEN;
        if (fin) return error_out(ERR_TRUNCATED, 1'b1, r);
      end
      PH_TAG2: begin
        if (b[7]) return error_out(ERR_TAG_LONG, fin, r);
        cur_tag     = b[6:0];
        parse_phase = PH_LEN;
        if (fin) return error_out(ERR_TRUNCATED, 1'b1, r);
      end
      PH_LEN: begin
        if (!b[7]) begin
          len_accum = {24'd0, b};
          return length_complete(fin, r);
        end
        if (b == LEN_INDEFINITE) return error_out(ERR_INDEFINITE, fin, r);
        if (b[6:0] > 7'(MAX_LENGTH_OCTETS)) return error_out(ERR_LEN_OCTETS, fin, r);
        len_octets_left = b[LO_W-1:0];
        len_accum       = 32'd0;
        parse_phase     = PH_LENOCT;
        if (fin) return error_out(ERR_TRUNCATED, 1'b1, r);
      end
      PH_LENOCT: begin
        len_accum = {len_accum[23:0], b};
        if (len_octets_left != '0) len_octets_left--;
        if (len_octets_left == '0) return length_complete(fin, r);
        if (fin) return error_out(ERR_TRUNCATED, 1'b1, r);
      end
      PH_VALUE: begin
        if (content_left != 32'd0) content_left--;
        if (content_left == 32'd0) begin
          r = tlv_out(KIND_VALUE, len_accum, b, ERR_NONE, 1'b1);
          parse_phase = PH_IDENT;
          return 1'b1;
        end
        if (fin) return error_out(ERR_TRUNCATED, 1'b1, r);
        r = tlv_out(KIND_VALUE, len_accum, b, ERR_NONE, 1'b0);
        return 1'b1;
      end
      default: begin
        // drop bytes until the buffer ends
        if (fin) parse_phase = PH_IDENT;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // One transfer on the input side; called at a falling edge, returns at one
  task automatic offer(input logic [7:0] b, input logic fin, input logic typed,
                       input tlv_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    offer_marks.push_back('{typed, want});
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Well-formed element: identifier, optional second tag byte, length, content
  function automatic void build_element(ref logic [7:0] q[$]);
    logic [7:0] id;
    int         vlen;
    int         nb;
    int         k;
    id = 8'($urandom);
    if ($urandom_range(0, 3) == 0) id[4:0] = TAG_LONG_FORM;
    q.push_back(id);
    if (id[4:0] == TAG_LONG_FORM) q.push_back({1'b0, 7'($urandom)});
    vlen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 60);
    if ($urandom_range(0, 3) == 0) begin
      nb = $urandom_range(1, MAX_LENGTH_OCTETS);
      q.push_back(LONG_LEN_FLAG | 8'(nb));
      for (k = nb - 1; k >= 0; k--) q.push_back(8'(vlen >> (8 * k)));
    end else begin
      q.push_back(8'(vlen));
    end
    for (k = 0; k < vlen; k++) q.push_back(8'($urandom));
  endfunction

  task automatic send_buffer();
    logic [7:0] q[$];
    logic [7:0] id;
    logic [7:0] bad;
    int         n_elem;
    int         mode;
    int         cut;
    int         n;
    int         i;
    int         j;
    calm   = ($urandom_range(0, 5) == 0);
    n_elem = $urandom_range(1, 4);
    for (i = 0; i < n_elem; i++) begin
      mode = $urandom_range(0, 99);
      q.delete();
      if (mode < 72) begin
        build_element(q);
        for (j = 0; j < q.size(); j++)
          offer(q[j], (i == n_elem - 1) && (j == q.size() - 1), 1'b0, NO_RESULT);
      end else if (mode < 82) begin
        // end the buffer somewhere inside or on the last byte of a valid element
        build_element(q);
        cut = $urandom_range(0, q.size() - 1);
        for (j = 0; j <= cut; j++) offer(q[j], j == cut, 1'b0, NO_RESULT);
        return;
      end else if (mode < 88) begin
        // wide random length, cut short among the content bytes
        id = 8'($urandom);
        if (id[4:0] == TAG_LONG_FORM) id[0] = 1'b0;
        offer(id, 1'b0, 1'b0, NO_RESULT);
        offer(LONG_LEN_FLAG | 8'(MAX_LENGTH_OCTETS), 1'b0, 1'b0, NO_RESULT);
        for (j = 0; j < MAX_LENGTH_OCTETS; j++) offer(8'($urandom), 1'b0, 1'b0, NO_RESULT);
        n = $urandom_range(0, 3);
        for (j = 0; j < n; j++) offer(8'($urandom), 1'b0, 1'b0, NO_RESULT);
        offer(8'($urandom), 1'b1, 1'b0, NO_RESULT);
        return;
      end else if (mode < 96) begin
        // header error, then zero to four trailing bytes to discard
        id = 8'($urandom);
        if ($urandom_range(0, 2) == 0) begin
          id[4:0] = TAG_LONG_FORM;
          bad = {1'b1, 7'($urandom)};
        end else begin
          if (id[4:0] == TAG_LONG_FORM) id[0] = 1'b0;
          bad = ($urandom_range(0, 1) == 0) ? LEN_INDEFINITE :
                LONG_LEN_FLAG | 8'($urandom_range(MAX_LENGTH_OCTETS + 1, 127));
        end
        n = $urandom_range(0, 4);
        offer(id, 1'b0, 1'b0, NO_RESULT);
        offer(bad, n == 0, 1'b0, NO_RESULT);
        for (j = 0; j < n; j++) offer(8'($urandom), j == n - 1, 1'b0, NO_RESULT);
        return;
      end else begin
        n = $urandom_range(1, 8);
        for (j = 0; j < n; j++) offer(8'($urandom), j == n - 1, 1'b0, NO_RESULT);
        return;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_phase     = PH_IDENT;
      cur_tag         = '0;
      cur_flags       = '0;
      len_octets_left = '0;
      len_accum       = '0;
      content_left    = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        mark     = offer_marks.pop_front();
        produced = decode_byte(s_tdata, s_tlast, predicted);
        if (mark.typed) pending_results.push_back(mark.want);
        else if (produced) pending_results.push_back(predicted);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: tuser %0h tdata %0h",
                 m_tuser, m_tdata);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          compare("kind", 32'(oldest.kind), 32'(m_tuser));
          compare("tag_number", 32'(oldest.tag), 32'(m_tdata[6:0]));
          compare("is_constructed", 32'(oldest.cons), 32'(m_tdata[7]));
          compare("is_context_specific", 32'(oldest.ctx), 32'(m_tdata[8]));
          compare("elem_length", oldest.len, m_tdata[40:9]);
          compare("value_byte", 32'(oldest.vbyte), 32'(m_tdata[48:41]));
          compare("error_code", 32'(oldest.err), 32'(m_tdata[51:49]));
          compare("last_of_element", 32'(oldest.last), 32'(m_tlast));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_der_tlv_header_parser_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input
  initial begin
    m_tready      = 1'b0;
    pressure_done = 1'b0;
    forever begin
      if (!pressure_done && results_seen >= 150) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end else begin
        rx_stall = pick_gap();
        if (rx_stall > 0) begin
          m_tready <= 1'b0;
          repeat (rx_stall) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    int i;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'd0;
    s_tlast       = 1'b0;
    calm          = 1'b0;
    items_sent    = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (i = 0; i < $size(DIRECTED_ROWS); i++)
      offer(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed,
            DIRECTED_ROWS[i].want);
    while (items_sent < ITEM_TARGET) send_buffer();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_der_tlv_header_parser_unit passed");
    else
      $display("tb_der_tlv_header_parser_unit failed");
    $finish;
  end

endmodule
`default_nettype wire
